// ===== hw/rtl/arpc_pkg.sv =====
// Shared types and constants for the ARP cache with aging.
// Used by the RAM-based datapath, the scan controller and the top level.
package arpc_pkg;

   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int STAMP_W = 16;
   localparam int LIMIT_W = 8;
   localparam int MODE_W  = 2;
   localparam int ENTRY_W = IP_W + MAC_W + STAMP_W;

   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [LIMIT_W-1:0] EXPIRY_RESET = 8'd15;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // capture the accepted item, clear results
      logic chk_en;     // evaluate the entry whose read data is present
      logic wr_en;      // commit a pending insert
      logic load_rsp;   // move results into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;       // zero key on a non-tick item: no scan
      logic stop;       // scan ends at the entry under evaluation
      logic rsp_free;   // output register can take a result this cycle
   } status_type;

endpackage

// ===== hw/rtl/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/arpc_datapath.sv =====
// Datapath of the ARP cache: entry RAM, valid bits, time counter,
// expiry register, result and output registers. Uses arpc_pkg and arpc_ram.
module arpc_datapath #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [arpc_pkg::LIMIT_W-1:0]      csr_wr_data,
   input  logic [arpc_pkg::MODE_W-1:0]       req_mode,
   input  logic [arpc_pkg::IP_W-1:0]         req_ip_key,
   input  logic [arpc_pkg::MAC_W-1:0]        req_mac_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic [arpc_pkg::MAC_W-1:0]        rsp_mac_out,
   output logic                              rsp_replaced,
   input  arpc_pkg::cmd_type                 cmd,
   input  logic [$clog2(ENTRIES)-1:0]        rd_addr,
   input  logic [$clog2(ENTRIES)-1:0]        chk_idx,
   output arpc_pkg::status_type              status
);
   import arpc_pkg::*;

   localparam int IW = $clog2(ENTRIES);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [IP_W-1:0]    key_ff, key_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               hit_ff, hit_in;
   logic [MAC_W-1:0]   macr_ff, macr_in;
   logic               repl_ff, repl_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [MAC_W-1:0]   rsp_mac_ff, rsp_mac_in;
   logic               rsp_repl_ff, rsp_repl_in;

   logic [ENTRY_W-1:0] rd_data;
   logic [IP_W-1:0]    ent_ip;
   logic [MAC_W-1:0]   ent_mac;
   logic [STAMP_W-1:0] ent_stamp;
   logic [STAMP_W-1:0] age;
   logic               cur_valid, match, expired, last, ram_wr;

   arpc_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (slot_ff),
      .wr_data ({key_ff, mac_ff, now_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_ip    = rd_data[ENTRY_W-1 -: IP_W];
   assign ent_mac   = rd_data[STAMP_W +: MAC_W];
   assign ent_stamp = rd_data[STAMP_W-1:0];
   assign age       = now_ff - ent_stamp;
   assign cur_valid = valid_ff[chk_idx];
   assign match     = (ent_ip == key_ff);
   assign expired   = (age > {{(STAMP_W-LIMIT_W){1'b0}}, limit_ff});
   assign last      = (chk_idx == IW'(ENTRIES-1));
   assign ram_wr    = cmd.wr_en && wr_pend_ff;

   always_comb begin
      case (mode_ff)
         MODE_INSERT: status.stop = !cur_valid || match;
         MODE_SEARCH: status.stop = cur_valid && match;
         default:     status.stop = 1'b0;
      endcase
      status.skip     = (mode_ff != MODE_TICK) && (key_ff == '0);
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      mode_in      = mode_ff;
      key_in       = key_ff;
      mac_in       = mac_ff;
      valid_in     = valid_ff;
      now_in       = now_ff;
      limit_in     = limit_ff;
      hit_in       = hit_ff;
      macr_in      = macr_ff;
      repl_in      = repl_ff;
      wr_pend_in   = wr_pend_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_mac_in   = rsp_mac_ff;
      rsp_repl_in  = rsp_repl_ff;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      if (cmd.load_req) begin
         mode_in    = req_mode;
         key_in     = req_ip_key;
         mac_in     = req_mac_value;
         hit_in     = 1'b0;
         macr_in    = '0;
         repl_in    = 1'b0;
         wr_pend_in = 1'b0;
         slot_in    = '0;
         if (req_mode == MODE_TICK) begin
            now_in = now_ff + STAMP_W'(1);
         end
      end

      if (cmd.chk_en) begin
         case (mode_ff)
            MODE_INSERT: begin
               if (!cur_valid) begin
                  wr_pend_in = 1'b1;
                  slot_in    = chk_idx;
               end else if (!match && last) begin
                  // table full: overwrite entry 0
                  wr_pend_in = 1'b1;
                  slot_in    = '0;
                  repl_in    = 1'b1;
               end
            end
            MODE_SEARCH: begin
               if (cur_valid && match) begin
                  hit_in  = 1'b1;
                  macr_in = ent_mac;
               end
            end
            MODE_ERASE: begin
               if (cur_valid && match) begin
                  valid_in[chk_idx] = 1'b0;
                  hit_in            = 1'b1;
               end
            end
            MODE_TICK: begin
               if (cur_valid && expired) begin
                  valid_in[chk_idx] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (ram_wr) begin
         valid_in[slot_ff] = 1'b1;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_mac_in   = macr_ff;
         rsp_repl_in  = repl_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         now_ff       <= '0;
         limit_ff     <= EXPIRY_RESET;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         now_ff       <= now_in;
         limit_ff     <= limit_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      mac_ff      <= mac_in;
      hit_ff      <= hit_in;
      macr_ff     <= macr_in;
      repl_ff     <= repl_in;
      slot_ff     <= slot_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_mac_ff  <= rsp_mac_in;
      rsp_repl_ff <= rsp_repl_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_mac_out  = rsp_mac_ff;
   assign rsp_replaced = rsp_repl_ff;

endmodule

// ===== hw/rtl/arpc_ctrl.sv =====
// Scan controller of the ARP cache: item acceptance, pipelined entry scan,
// insert commit and result hand-off. Uses arpc_pkg.
module arpc_ctrl #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   output arpc_pkg::cmd_type            cmd,
   output logic [$clog2(ENTRIES)-1:0]   rd_addr,
   output logic [$clog2(ENTRIES)-1:0]   chk_idx,
   input  arpc_pkg::status_type         status
);
   import arpc_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic          issuing, last;

   assign issuing = (issue_ff < CW'(ENTRIES));
   assign last    = (chk_idx_ff == IW'(ENTRIES-1));

   always_comb begin
      state_in   = state_ff;
      issue_in   = issue_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      cmd        = '0;
      req_stall  = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            issue_in = '0;
            state_in = status.skip ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.chk_en = chk_vld_ff;
            if (chk_vld_ff && (status.stop || last)) begin
               state_in = ST_WRITE;
            end else begin
               // advance the read address while entries remain
               chk_vld_in = issuing;
               chk_idx_in = issue_ff[IW-1:0];
               if (issuing) begin
                  issue_in = issue_ff + CW'(1);
               end
            end
         end
         ST_WRITE: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
   end

   assign rd_addr = issue_ff[IW-1:0];
   assign chk_idx = chk_idx_ff;

endmodule

// ===== hw/rtl/arp_cache_with_aging.sv =====
// ARP cache with aging: IPv4 to MAC table scanned serially through arpc_ctrl,
// arpc_datapath and arpc_ram, with shared types from arpc_pkg.
// Each item passes the start, scan, write and done states; insert and search
// end the scan early, and a zero key on a non-tick item skips it. No new item
// is taken until the last result is loaded; a stalled result holds the next one at the output.
// Reset (synchronous): all entries invalid, time zero, expiry limit 15.
module arp_cache_with_aging #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // expiry limit register
   input  logic                          csr_wr_en,
   input  logic [arpc_pkg::LIMIT_W-1:0]  csr_wr_data,
   // request items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [arpc_pkg::MODE_W-1:0]   req_mode,
   input  logic [arpc_pkg::IP_W-1:0]     req_ip_key,
   input  logic [arpc_pkg::MAC_W-1:0]    req_mac_value,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [arpc_pkg::MAC_W-1:0]    rsp_mac_out,
   output logic                          rsp_replaced
);
   import arpc_pkg::*;

   localparam int IW = $clog2(ENTRIES);

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] chk_idx;

   // The controller walks the entries: one RAM read issued per cycle, the
   // entry read in the previous cycle is evaluated against the held item.
   // Inserts commit their single RAM write after the scan ends.
   arpc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .chk_idx   (chk_idx),
      .status    (status)
   );

   // The output register lets a finished result wait while the next item
   // is already taken in and scanned.
   arpc_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mode      (req_mode),
      .req_ip_key    (req_ip_key),
      .req_mac_value (req_mac_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_mac_out   (rsp_mac_out),
      .rsp_replaced  (rsp_replaced),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .chk_idx       (chk_idx),
      .status        (status)
   );

   // Hold off new items once one is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous item still in flight");

   // Load the output register only when it is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("result loaded over an undelivered result");

   // Never commit an insert while the scan is still evaluating entries.
   a_write_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !cmd.chk_en)
      else $error("entry write overlaps scan");

   // Drop the MAC on anything but a hit.
   a_mac_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_mac_out == '0))
      else $error("nonzero MAC without hit");

endmodule

// ===== bench/arp_cache_checker.sv =====
// Watches the request, result and limit ports of the ARP cache, keeps its own
// copy of the table and the aging clock, and checks every result item.
// Depends on arpc_pkg for widths, mode codes and the expiry reset value.
module arp_cache_checker #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [arpc_pkg::LIMIT_W-1:0]  csr_wr_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [arpc_pkg::MODE_W-1:0]   req_mode,
   input  logic [arpc_pkg::IP_W-1:0]     req_ip_key,
   input  logic [arpc_pkg::MAC_W-1:0]    req_mac_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_hit,
   input  logic [arpc_pkg::MAC_W-1:0]    rsp_mac_out,
   input  logic                          rsp_replaced,
   output int                            awaiting,
   output int                            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import arpc_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [MAC_W-1:0] mac;
      logic             replaced;
   } answer_type;

   logic               entry_live [ENTRIES];
   logic [IP_W-1:0]    entry_key  [ENTRIES];
   logic [MAC_W-1:0]   entry_hw   [ENTRIES];
   logic [STAMP_W-1:0] entry_born [ENTRIES];
   logic [STAMP_W-1:0] now_ticks;
   logic [LIMIT_W-1:0] age_limit;

   answer_type expected_answers [$];
   int         pending_count = 0;
   int         mismatches = 0;

   assign awaiting   = pending_count;
   assign fail_count = mismatches;

   // Apply one request to the table copy and return the answer it earns.
   function automatic answer_type resolve_request(input logic [MODE_W-1:0] mode,
                                                  input logic [IP_W-1:0]   key,
                                                  input logic [MAC_W-1:0]  mac);
      answer_type         ans;
      int                 slot;
      logic               dup;
      logic               done;
      logic [STAMP_W-1:0] age;
      ans  = '0;
      slot = -1;
      dup  = 1'b0;
      done = 1'b0;
      case (mode)
         MODE_INSERT: begin
            if (key != '0) begin
               // first free entry wins, even with a match further on
               for (int k = 0; k < ENTRIES; k++) begin
                  if (!done) begin
                     if (!entry_live[k]) begin
                        slot = k;
                        done = 1'b1;
                     end else if (entry_key[k] == key) begin
                        dup  = 1'b1;
                        done = 1'b1;
                     end
                  end
               end
               if (!dup) begin
                  if (slot < 0) begin
                     slot         = 0;
                     ans.replaced = 1'b1;
                  end
                  entry_live[slot] = 1'b1;
                  entry_key[slot]  = key;
                  entry_hw[slot]   = mac;
                  entry_born[slot] = now_ticks;
               end
            end
         end
         MODE_SEARCH: begin
            if (key != '0) begin
               for (int k = 0; k < ENTRIES; k++) begin
                  if (!done && entry_live[k] && entry_key[k] == key) begin
                     ans.hit = 1'b1;
                     ans.mac = entry_hw[k];
                     done    = 1'b1;
                  end
               end
            end
         end
         MODE_ERASE: begin
            if (key != '0) begin
               for (int k = 0; k < ENTRIES; k++) begin
                  if (entry_live[k] && entry_key[k] == key) begin
                     entry_live[k] = 1'b0;
                     ans.hit       = 1'b1;
                  end
               end
            end
         end
         default: begin
            now_ticks = now_ticks + 1'b1;
            for (int k = 0; k < ENTRIES; k++) begin
               if (entry_live[k]) begin
                  age = now_ticks - entry_born[k];
                  if (age > age_limit) begin
                     entry_live[k] = 1'b0;
                  end
               end
            end
         end
      endcase
      return ans;
   endfunction

   // Inputs move only at rising edges, so what is seen here is what the
   // next edge will take.
   always @(negedge clock) begin : watch
      answer_type got;
      answer_type want;
      if (reset) begin
         for (int k = 0; k < ENTRIES; k++) begin
            entry_live[k] = 1'b0;
         end
         now_ticks = '0;
         age_limit = EXPIRY_RESET;
         expected_answers.delete();
      end else begin
         if (csr_wr_en) begin
            age_limit = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            expected_answers.push_back(resolve_request(req_mode, req_ip_key,
                                                       req_mac_value));
         end
         if (rsp_valid && !rsp_stall) begin
            got.hit      = rsp_hit;
            got.mac      = rsp_mac_out;
            got.replaced = rsp_replaced;
            if (expected_answers.size() == 0) begin
               $error("unexpected result item: hit %0d mac_out %h replaced %0d",
                      got.hit, got.mac, got.replaced);
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                  mismatches++;
               end
               if (got.mac !== want.mac) begin
                  $error("mac_out: expected %h, actual %h", want.mac, got.mac);
                  mismatches++;
               end
               if (got.replaced !== want.replaced) begin
                  $error("replaced: expected %0d, actual %0d",
                         want.replaced, got.replaced);
                  mismatches++;
               end
            end
         end
      end
      pending_count = expected_answers.size();
   end

endmodule

// ===== bench/arp_cache_with_aging_tb.sv =====
// Top of the ARP cache bench: clock, reset, request stimulus, result-side
// stalls and the verdict. Uses arpc_pkg, arp_cache_checker and the cache RTL.
module arp_cache_with_aging_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import arpc_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int KEY_POOL     = 20;
   localparam int RANDOM_ITEMS = 960;

   // fixed keys for the directed part
   localparam logic [IP_W-1:0] KEY_HI   = 32'hFFFF_FFFF;
   localparam logic [IP_W-1:0] KEY_LO   = 32'h0000_0001;
   localparam logic [IP_W-1:0] KEY_MID  = 32'hC0A8_0101;
   localparam logic [IP_W-1:0] KEY_AGED = 32'h7F00_0001;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [MODE_W-1:0]  req_mode = MODE_SEARCH;
   logic [IP_W-1:0]    req_ip_key = '0;
   logic [MAC_W-1:0]   req_mac_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;
   logic [MAC_W-1:0]   rsp_mac_out;
   logic               rsp_replaced;

   int                 awaiting;
   int                 fail_count;
   int                 cycle_count = 0;
   logic               quiet = 1'b0;      // suppress idling on both sides
   logic [IP_W-1:0]    key_pool [KEY_POOL];

   always #5ns clock = ~clock;

   arp_cache_with_aging #(
      .ENTRIES(ENTRIES)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_ip_key    (req_ip_key),
      .req_mac_value (req_mac_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_mac_out   (rsp_mac_out),
      .rsp_replaced  (rsp_replaced)
   );

   arp_cache_checker #(
      .ENTRIES(ENTRIES)
   ) table_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_ip_key    (req_ip_key),
      .req_mac_value (req_mac_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_mac_out   (rsp_mac_out),
      .rsp_replaced  (rsp_replaced),
      .awaiting      (awaiting),
      .fail_count    (fail_count)
   );

   // Gap length: mostly none, sometimes a few cycles, rarely a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[MAC_W-1:0];
   endfunction

   // Mostly keys from a small pool so that hits, duplicates and a full
   // table are common; now and then a fresh key or the rejected zero key.
   function automatic logic [IP_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 90) begin
         return key_pool[$urandom_range(0, KEY_POOL - 1)];
      end
      if (roll < 97) begin
         return $urandom;
      end
      return '0;
   endfunction

   // Offer one item and hold it until the block takes it. Called at a
   // rising edge; returns at the edge that accepted the item, so the next
   // call drives in the same step and valid stays up across back-to-back
   // items.
   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic [IP_W-1:0]   key,
                            input logic [MAC_W-1:0]  mac);
      int   gap;
      logic taken;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_ip_key    <= key;
      req_mac_value <= mac;
      // sample stall mid-cycle, where it is settled
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Drop valid and wait until every result item has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   // Change the expiry limit only while the block is idle.
   task automatic write_limit(input logic [LIMIT_W-1:0] limit);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_traffic(input int count);
      int                roll;
      logic [MODE_W-1:0] mode;
      for (int i = 0; i < count; i++) begin
         // alternate calm stretches with idling ones
         if (i % 100 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            mode = MODE_INSERT;
         end else if (roll < 65) begin
            mode = MODE_SEARCH;
         end else if (roll < 78) begin
            mode = MODE_ERASE;
         end else begin
            mode = MODE_TICK;
         end
         send_item(mode, pick_key(), rand_mac());
      end
      quiet = 1'b0;
   endtask

   // Result-side stalls: hold stall for a drawn number of cycles, then draw
   // again. Never lowered and raised in the same step.
   initial begin : rsp_idle
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            hold = quiet ? 0 : pick_gap();
            rsp_stall <= (hold > 0);
            if (hold > 0) begin
               hold--;
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      for (int k = 0; k < KEY_POOL; k++) begin
         do key_pool[k] = $urandom; while (key_pool[k] == '0);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, zero key on every keyed mode, extremes of
      // key and MAC, duplicate insert, erase hit and miss.
      send_item(MODE_SEARCH, KEY_HI, rand_mac());
      send_item(MODE_INSERT, '0, '1);
      send_item(MODE_SEARCH, '0, rand_mac());
      send_item(MODE_ERASE, '0, rand_mac());
      send_item(MODE_INSERT, KEY_HI, '1);
      send_item(MODE_INSERT, KEY_LO, '0);
      send_item(MODE_SEARCH, KEY_HI, rand_mac());
      send_item(MODE_SEARCH, KEY_LO, rand_mac());
      send_item(MODE_INSERT, KEY_HI, 48'h0123_4567_89AB);  // must not refresh
      send_item(MODE_SEARCH, KEY_HI, rand_mac());
      send_item(MODE_ERASE, KEY_LO, rand_mac());
      send_item(MODE_ERASE, KEY_LO, rand_mac());
      // Scan order: free entry 1, then free entry 0 ahead of a live match,
      // so the same key lands twice and erase removes both copies.
      send_item(MODE_INSERT, KEY_MID, 48'h5555_5555_5555);
      send_item(MODE_ERASE, KEY_HI, rand_mac());
      send_item(MODE_INSERT, KEY_MID, 48'hAAAA_AAAA_AAAA);
      send_item(MODE_SEARCH, KEY_MID, rand_mac());
      send_item(MODE_ERASE, KEY_MID, rand_mac());
      send_item(MODE_SEARCH, KEY_MID, rand_mac());
      // Ticks ignore key and MAC; all result fields stay zero.
      send_item(MODE_TICK, KEY_HI, '1);
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_SEARCH, 32'h8000_0000, rand_mac());

      // Full table and fastest aging: fill every entry, overwrite entry 0,
      // then one tick expires everything.
      write_limit('0);
      for (int i = 0; i <= ENTRIES; i++) begin
         send_item(MODE_INSERT, 32'h0A00_0001 + (i << 8), rand_mac());
      end
      send_item(MODE_SEARCH, 32'h0A00_0001 + (ENTRIES << 8), rand_mac());
      send_item(MODE_SEARCH, 32'h0A00_0001, rand_mac());
      send_item(MODE_TICK, $urandom, rand_mac());
      send_item(MODE_SEARCH, 32'h0A00_0001 + (ENTRIES << 8), rand_mac());

      // Longest limit: store an entry and age it to exactly the limit, then
      // one tick past it.
      write_limit('1);
      quiet = 1'b1;
      send_item(MODE_INSERT, KEY_AGED, rand_mac());
      repeat (255) send_item(MODE_TICK, $urandom, rand_mac());
      send_item(MODE_SEARCH, KEY_AGED, rand_mac());
      send_item(MODE_TICK, $urandom, rand_mac());
      send_item(MODE_SEARCH, KEY_AGED, rand_mac());
      quiet = 1'b0;

      // Random traffic under several limits.
      write_limit(8'd6);
      random_traffic(RANDOM_ITEMS / 4);
      write_limit('1);
      random_traffic(RANDOM_ITEMS / 4);
      write_limit(8'($urandom_range(0, 255)));
      random_traffic(RANDOM_ITEMS / 4);
      write_limit(8'd1);
      random_traffic(RANDOM_ITEMS / 4);

      // Let any stray result show up before the verdict.
      drain();
      repeat (ENTRIES + 8) @(posedge clock);
      if (fail_count == 0 && awaiting == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
